### src/sort_dedup_points_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for sort_dedup_points_core
// Implication checks, same-cycle and next-cycle, clocked on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef SORT_DEDUP_POINTS_CORE_ASSERT_SVH
`define SORT_DEDUP_POINTS_CORE_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define SDP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdp assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define SDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdp assertion failed");

`endif

### src/sdp_pkg.sv
// ---------------------------------------------------------------------------
// sdp_pkg
// Shared constants, the point record and the ordering function for the
// sort/dedup chain.
// ---------------------------------------------------------------------------
package sdp_pkg;

    // one cell per storable point
    localparam int CELLS   = 64;
    localparam int COORD_W = 32;
    localparam int FILL_W  = $clog2(CELLS + 1);
    localparam int FLUSH_W = $clog2(CELLS);

    typedef struct packed {
        logic               valid;
        logic               dup;    // seen two or more times
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } point_t;

    // strict order: signed x, then signed y
    function automatic logic point_less(input point_t a, input point_t b);
        logic [2*COORD_W-1:0] ka;
        logic [2*COORD_W-1:0] kb;
        ka = {~a.x[COORD_W-1], a.x[COORD_W-2:0], ~a.y[COORD_W-1], a.y[COORD_W-2:0]};
        kb = {~b.x[COORD_W-1], b.x[COORD_W-2:0], ~b.y[COORD_W-1], b.y[COORD_W-2:0]};
        return ka < kb;
    endfunction

endpackage

### src/sdp_cell.sv
// ---------------------------------------------------------------------------
// sdp_cell
// One insertion cell: keeps the smaller of held and incoming point, passes
// the larger on, merges equal points; shifts towards the head when draining.
// ---------------------------------------------------------------------------
module sdp_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  sdp_pkg::point_t tok_in,
    input  sdp_pkg::point_t shift_in,
    output sdp_pkg::point_t tok_out,
    output sdp_pkg::point_t held
);

    sdp_pkg::point_t held_reg;
    sdp_pkg::point_t held_next;
    sdp_pkg::point_t tok_reg;
    sdp_pkg::point_t tok_next;
    logic            same;

    assign same = (tok_in.x == held_reg.x) && (tok_in.y == held_reg.y);

    always_comb
    begin
        held_next       = held_reg;
        tok_next        = tok_in;
        tok_next.valid  = 1'b0;
        if (shift)
        begin
            held_next = shift_in;
        end
        else if (tok_in.valid)
        begin
            if (!held_reg.valid)
            begin
                held_next = tok_in;
            end
            else if (same)
            begin
                held_next.dup = 1'b1;
            end
            else if (sdp_pkg::point_less(tok_in, held_reg))
            begin
                held_next = tok_in;
                tok_next  = held_reg;
            end
            else
            begin
                tok_next = tok_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            held_reg <= held_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign held    = held_reg;

endmodule

### src/sort_dedup_points_core.sv
// ---------------------------------------------------------------------------
// sort_dedup_points_core
// Loads a set of points into a chain of insertion cells, then drains the
// sorted, merged runs out of the head (only repeated ones with drop_singletons).
// ---------------------------------------------------------------------------
// channel   direction  handshake               payload
// request   in         start & !busy           point_x, point_y, last_point
// result    out        out_valid (one cycle)   out_x, out_y, out_last,
//                                              set_empty, overflowed
// config    in         cfg_we                  cfg_wdata (drop_singletons)
//
// Points load one per cycle while busy is low; each ripples one cell per cycle.
// After the last point busy rises while the chain settles in the flush state;
// then the drain shifts the held points out of the head in order, and each
// surviving point goes out, registered, once the next one or the end is seen.
// Reset clears the chain and the control state and sets drop_singletons; no clearing pass is needed.
// The receiver cannot stall; results are never held back.
// ---------------------------------------------------------------------------
module sort_dedup_points_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] point_x,
    input  logic [31:0] point_y,
    input  logic        last_point,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    output logic        out_valid,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic        out_last,
    output logic        set_empty,
    output logic        overflowed
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [sdp_pkg::FILL_W-1:0]   fill_count_reg, fill_count_next;
    logic                         ovf_reg, ovf_next;
    logic [sdp_pkg::FLUSH_W-1:0]  flush_cnt_reg, flush_cnt_next;
    logic                         drop_reg;
    logic                         pend_valid_reg, pend_valid_next;
    logic [31:0]                  pend_x_reg, pend_x_next;
    logic [31:0]                  pend_y_reg, pend_y_next;
    logic                         out_valid_reg, out_valid_next;
    logic [31:0]                  out_x_reg, out_x_next;
    logic [31:0]                  out_y_reg, out_y_next;
    logic                         out_last_reg, out_last_next;
    logic                         set_empty_reg, set_empty_next;
    logic                         out_ovf_reg, out_ovf_next;

    logic                         accept;
    logic                         full;
    logic                         shift;
    logic                         keep;
    sdp_pkg::point_t              tok  [0:sdp_pkg::CELLS];
    sdp_pkg::point_t              held [0:sdp_pkg::CELLS];

    assign busy   = (state_reg != ST_LOAD);
    assign accept = start && !busy;
    assign full   = (fill_count_reg == sdp_pkg::FILL_W'(sdp_pkg::CELLS));
    assign shift  = (state_reg == ST_DRAIN);

    always_comb
    begin
        tok[0].valid = accept && !full;
        tok[0].dup   = 1'b0;
        tok[0].x     = point_x;
        tok[0].y     = point_y;
    end

    assign held[sdp_pkg::CELLS] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < sdp_pkg::CELLS; gi++)
        begin : g_cell
            sdp_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (shift),
                .tok_in   (tok[gi]),
                .shift_in (held[gi+1]),
                .tok_out  (tok[gi+1]),
                .held     (held[gi])
            );
        end
    endgenerate

    // head cell survives the drain filter
    assign keep = held[0].valid && (!drop_reg || held[0].dup);

    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        ovf_next        = ovf_reg;
        flush_cnt_next  = flush_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        out_valid_next  = 1'b0;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_last_next   = 1'b0;
        set_empty_next  = 1'b0;
        out_ovf_next    = out_ovf_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (full)
                        ovf_next = 1'b1;
                    else
                        fill_count_next = fill_count_reg + 1'b1;
                    if (last_point)
                    begin
                        state_next     = ST_FLUSH;
                        flush_cnt_next = '0;
                    end
                end
            end
            ST_FLUSH:
            begin
                flush_cnt_next = flush_cnt_reg + 1'b1;
                if (flush_cnt_reg == sdp_pkg::FLUSH_W'(sdp_pkg::CELLS - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (held[0].valid)
                begin
                    if (keep)
                    begin
                        // previous survivor is known not to be the last
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_x_next     = pend_x_reg;
                            out_y_next     = pend_y_reg;
                            out_ovf_next   = ovf_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_x_next     = held[0].x;
                        pend_y_next     = held[0].y;
                    end
                end
                else
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_ovf_next    = ovf_reg;
                    set_empty_next  = !pend_valid_reg;
                    out_x_next      = pend_valid_reg ? pend_x_reg : '0;
                    out_y_next      = pend_valid_reg ? pend_y_reg : '0;
                    pend_valid_next = 1'b0;
                    fill_count_next = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            fill_count_reg <= '0;
            ovf_reg        <= 1'b0;
            flush_cnt_reg  <= '0;
            drop_reg       <= 1'b1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            set_empty_reg  <= 1'b0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            ovf_reg        <= ovf_next;
            flush_cnt_reg  <= flush_cnt_next;
            if (cfg_we)
                drop_reg <= cfg_wdata;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
            set_empty_reg  <= set_empty_next;
            out_ovf_reg    <= out_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_x_reg <= pend_x_next;
        pend_y_reg <= pend_y_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_last   = out_last_reg;
    assign set_empty  = set_empty_reg;
    assign overflowed = out_ovf_reg;

`include "sort_dedup_points_core_assert.svh"

    `SDP_ASSERT_IMPL(a_empty_is_last, out_valid && set_empty, out_last && out_x == 32'd0)
    `SDP_ASSERT_IMPL(a_mid_result_in_drain, out_valid && !out_last, state_reg == ST_DRAIN)
    `SDP_ASSERT_IMPL(a_last_ends_set, out_valid && out_last,
                     state_reg == ST_LOAD && fill_count_reg == '0 && !ovf_reg)
    `SDP_ASSERT_NEXT(a_last_point_busy, accept && last_point, busy)
    `SDP_ASSERT_IMPL(a_no_token_in_drain, state_reg == ST_DRAIN || tok[sdp_pkg::CELLS].valid,
                     !tok[1].valid && !tok[sdp_pkg::CELLS].valid)

endmodule

### verif/sort_dedup_points_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sort_dedup_points_core_tb
// Feeds point sets through the sort/merge core, rebuilds each sorted and
// merged set in a behavioural copy, and checks every result strobe against
// it. Covers both modes, coordinate extremes, empty and overflowing sets.
// ---------------------------------------------------------------------------
module sort_dedup_points_core_tb;

    localparam int CAPACITY    = sdp_pkg::CELLS;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
    } coord_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
        int          gap;
    } point_req_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
        logic        empty;
        logic        ovf;
    } run_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] point_x = '0;
    logic [31:0] point_y = '0;
    logic        last_point = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        out_valid;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic        out_last;
    logic        set_empty;
    logic        overflowed;

    point_req_t req_fifo[$];
    run_out_t   sorted_runs[$];

    // shadow of the block state
    coord_t     held_points[$];
    bit         drop_seen = 1'b0;
    bit         only_dups = 1'b1;

    point_req_t cur_req;
    bit         have_cur = 1'b0;
    int         wait_left = 0;
    int         errors = 0;
    int         cycles = 0;
    run_out_t   got_run;
    run_out_t   want_run;

    sort_dedup_points_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_valid  (out_valid),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_last   (out_last),
        .set_empty  (set_empty),
        .overflowed (overflowed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit coord_less(coord_t a, coord_t b);
        if (a.x != b.x)
            return $signed(a.x) < $signed(b.x);
        return $signed(a.y) < $signed(b.y);
    endfunction

    // accept one point; on the final one sort, merge, filter and queue the runs
    function automatic void take_point(logic [31:0] x, logic [31:0] y, logic last);
        coord_t   srt[$];
        coord_t   p;
        run_out_t runs[$];
        run_out_t r;
        int       i;
        int       j;
        int       run;
        int       n;
        p.x = x;
        p.y = y;
        if (held_points.size() < CAPACITY)
            held_points = {held_points, p};
        else
            drop_seen = 1'b1;
        if (!last)
            return;
        n = held_points.size();
        for (i = 0; i < n; i++)
        begin
            srt = {srt, held_points[i]};
            j = i;
            while (j > 0 && coord_less(held_points[i], srt[j-1]))
            begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = held_points[i];
        end
        i = 0;
        while (i < n)
        begin
            run = 1;
            while (i + run < n && srt[i+run] == srt[i])
                run++;
            if (!only_dups || run > 1)
            begin
                r.x     = srt[i].x;
                r.y     = srt[i].y;
                r.last  = 1'b0;
                r.empty = 1'b0;
                r.ovf   = drop_seen;
                runs = {runs, r};
            end
            i += run;
        end
        if (runs.size() == 0)
        begin
            r.x     = '0;
            r.y     = '0;
            r.last  = 1'b0;
            r.empty = 1'b1;
            r.ovf   = drop_seen;
            runs = {runs, r};
        end
        for (i = 0; i < runs.size(); i++)
        begin
            r = runs[i];
            r.last = (i == runs.size() - 1);
            sorted_runs = {sorted_runs, r};
        end
        held_points.delete();
        drop_seen = 1'b0;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            point_x    <= '0;
            point_y    <= '0;
            last_point <= 1'b0;
            have_cur   = 1'b0;
            wait_left  = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                take_point(cur_req.x, cur_req.y, cur_req.last);
                have_cur = 1'b0;
            end
            if (!have_cur && req_fifo.size() != 0)
            begin
                cur_req   = req_fifo.pop_front();
                have_cur  = 1'b1;
                wait_left = cur_req.gap;
            end
            if (have_cur && wait_left == 0)
            begin
                start      <= 1'b1;
                point_x    <= cur_req.x;
                point_y    <= cur_req.y;
                last_point <= cur_req.last;
            end
            else
            begin
                start <= 1'b0;
                if (have_cur)
                    wait_left--;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid)
        begin
            got_run = {out_x, out_y, out_last, set_empty, overflowed};
            if (sorted_runs.size() == 0)
            begin
                $display("%0t: unexpected result x=%h y=%h last=%b empty=%b ovf=%b",
                         $time, out_x, out_y, out_last, set_empty, overflowed);
                errors++;
            end
            else
            begin
                want_run = sorted_runs.pop_front();
                if (got_run !== want_run)
                begin
                    $display("%0t: mismatch expected x=%h y=%h last=%b empty=%b ovf=%b",
                             $time, want_run.x, want_run.y, want_run.last,
                             want_run.empty, want_run.ovf);
                    $display("%0t:          actual   x=%h y=%h last=%b empty=%b ovf=%b",
                             $time, got_run.x, got_run.y, got_run.last,
                             got_run.empty, got_run.ovf);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_point(logic [31:0] x, logic [31:0] y, logic last, int gmax);
        point_req_t q;
        q.x    = x;
        q.y    = y;
        q.last = last;
        q.gap  = $urandom_range(0, gmax);
        req_fifo = {req_fifo, q};
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_fifo.size() != 0 || have_cur || start || busy || sorted_runs.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_mode(logic v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        only_dups = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_random_set(int n, int gmax);
        logic [31:0] pal[6];
        int          psz;
        int          k;
        logic [31:0] x;
        logic [31:0] y;
        psz = $urandom_range(1, 6);
        for (k = 0; k < 6; k++)
        begin
            case ($urandom_range(0, 3))
                0: pal[k] = $urandom();
                1: pal[k] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
                2: pal[k] = 32'($urandom_range(0, 4)) - 32'd2;
                default: pal[k] = {16'($urandom_range(0, 65535)), 16'h0000};
            endcase
        end
        for (k = 0; k < n; k++)
        begin
            x = ($urandom_range(0, 5) == 0) ? $urandom() : pal[$urandom_range(0, psz - 1)];
            y = ($urandom_range(0, 5) == 0) ? $urandom() : pal[$urandom_range(0, psz - 1)];
            push_point(x, y, k == n - 1, gmax);
        end
    endtask

    initial
    begin
        int rand_items;
        int nsets;
        int s;
        int n;
        int k;
        int gmax;
        logic mode;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // merged-only mode: lone point gives an empty set
        write_mode(1'b1);
        push_point(32'd5, 32'd5, 1'b1, 10);
        push_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 10);
        push_point(32'h8000_0000, 32'h8000_0000, 1'b0, 0);
        push_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 0);
        push_point(32'h0000_0000, 32'h0000_0001, 1'b0, 10);
        push_point(32'h8000_0000, 32'h8000_0000, 1'b0, 0);
        push_point(32'h0000_0000, 32'hffff_ffff, 1'b0, 10);
        push_point(32'h0000_0000, 32'h0000_0001, 1'b1, 0);
        wait_drained();

        // every distinct point kept; sign of x and y in the ordering
        write_mode(1'b0);
        push_point(32'hffff_ffff, 32'h8000_0000, 1'b1, 0);
        push_point(32'h0000_0001, 32'h8000_0000, 1'b0, 10);
        push_point(32'h0000_0001, 32'h7fff_ffff, 1'b0, 10);
        push_point(32'hffff_ffff, 32'h0000_0000, 1'b0, 0);
        push_point(32'h0000_0001, 32'h8000_0000, 1'b0, 0);
        push_point(32'h8000_0000, 32'h7fff_ffff, 1'b1, 10);
        push_point(32'haaaa_aaaa, 32'h5555_5555, 1'b0, 0);
        push_point(32'h5555_5555, 32'haaaa_aaaa, 1'b1, 0);
        wait_drained();

        // store overflow, final mark on a dropped point
        for (k = 0; k < CAPACITY + 2; k++)
            push_point(32'(k >> 1), 32'h8000_0000, k == CAPACITY + 1, 1);
        wait_drained();

        // overflow with nothing surviving
        write_mode(1'b1);
        for (k = 0; k < CAPACITY + 1; k++)
            push_point(32'(k) << 16, 32'(-k), k == CAPACITY, 0);
        wait_drained();

        rand_items = 0;
        mode = 1'b0;
        while (rand_items < 30)
        begin
            write_mode(mode);
            nsets = $urandom_range(2, 5);
            for (s = 0; s < nsets; s++)
            begin
                k = $urandom_range(0, 99);
                if (k < 70)
                    n = $urandom_range(1, 8);
                else if (k < 90)
                    n = $urandom_range(9, 24);
                else if (k < 97)
                    n = $urandom_range(25, CAPACITY);
                else
                    n = $urandom_range(CAPACITY + 1, CAPACITY + 6);
                gmax = ($urandom_range(0, 2) == 0) ? 0 : 10;
                queue_random_set(n, gmax);
                rand_items += n;
            end
            // hold the sender until every run has come out
            wait_drained();
            mode = $urandom_range(0, 1);
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (errors == 0 && sorted_runs.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/sdp_pkg.sv
src/sdp_cell.sv
src/sort_dedup_points_core.sv
verif/sort_dedup_points_core_tb.sv
